// File: src/rc_pwm_pulse_decoder_macros.svh
// Assertion macros used by the checker file of the RC PWM pulse decoder.
// No dependencies; included by bare file name.
`ifndef RC_PWM_PULSE_DECODER_MACROS_SVH
`define RC_PWM_PULSE_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RPD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rpd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rpd assertion failed");

`endif

// File: src/rpd_pkg.sv
// Package of the RC PWM pulse decoder: field widths, register indexes,
// reset values, controller states, and the command and status structs.
package rpd_pkg;

    localparam int PULSE_W   = 15;
    localparam int PERIOD_W  = 16;
    localparam int TIMEOUT_W = 24;
    localparam int PCT_W     = 7;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;
    localparam int CNT_W     = 3;
    // Scaled numerator (pulse - min) * 100 fits in 22 bits.
    localparam int NUM_W     = 22;
    localparam int DIV_W     = PULSE_W + PCT_W - 1;

    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_MIN_PULSE  = 3'd0;
    localparam cfg_idx_t REG_MAX_PULSE  = 3'd1;
    localparam cfg_idx_t REG_MIN_PERIOD = 3'd2;
    localparam cfg_idx_t REG_MAX_PERIOD = 3'd3;
    localparam cfg_idx_t REG_TIMEOUT    = 3'd4;

    localparam logic [PULSE_W-1:0]   RST_MIN_PULSE  = 15'd1000;
    localparam logic [PULSE_W-1:0]   RST_MAX_PULSE  = 15'd2000;
    localparam logic [PERIOD_W-1:0]  RST_MIN_PERIOD = 16'd10000;
    localparam logic [PERIOD_W-1:0]  RST_MAX_PERIOD = 16'd30000;
    localparam logic [TIMEOUT_W-1:0] RST_TIMEOUT    = 24'd100000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SYMBOL,
        ST_COMMIT,
        ST_AGE,
        ST_PREP,
        ST_DIVIDE,
        ST_RESULT
    } ctl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;
        logic measure;
        logic eval_symbol;
        logic commit;
        logic prep;
        logic div_step;
        logic publish;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_valid;
        logic in_action;
        logic is_last;
        logic div_skip;
        logic div_last;
        logic out_free;
    } ctl_status_t;

endpackage

// File: src/rpd_if.sv
// Channel interfaces of the RC PWM pulse decoder: the item channel and the
// result channel. Depends on rpd_pkg.
interface rpd_item_if #(
    parameter int TIMESTAMP_BITS = 48,
    parameter int DURATION_BITS  = 15
);
    logic                      valid;
    logic                      ready;
    logic                      action;
    logic                      level_first;
    logic [DURATION_BITS-1:0]  duration_first;
    logic                      level_second;
    logic [DURATION_BITS-1:0]  duration_second;
    logic                      batch_last;
    logic [TIMESTAMP_BITS-1:0] now_us;

    modport source (
        output valid, action, level_first, duration_first, level_second,
               duration_second, batch_last, now_us,
        input  ready
    );
    modport sink (
        input  valid, action, level_first, duration_first, level_second,
               duration_second, batch_last, now_us,
        output ready
    );
endinterface

interface rpd_result_if;
    import rpd_pkg::*;

    logic                valid;
    logic                ready;
    logic [PULSE_W-1:0]  pulse_width;
    logic [PERIOD_W-1:0] period_width;
    logic                signal_ok;
    logic [PCT_W-1:0]    percentage;

    modport source (
        output valid, pulse_width, period_width, signal_ok, percentage,
        input  ready
    );
    modport sink (
        input  valid, pulse_width, period_width, signal_ok, percentage,
        output ready
    );
endinterface

// File: src/rc_pwm_pulse_decoder.sv
// Top level of the RC PWM pulse decoder: controller plus datapath.
// Depends on rpd_pkg, rpd_if.sv, rpd_ctrl and rpd_datapath.
//
// The block takes one item at a time. A symbol is evaluated in the symbol
// state; a commit state follows to commit pulse, period and update time when
// it closes a batch. A query runs the age and prep states, then the 7-step
// restoring divider for (pulse - min_pulse) * 100 / span, one quotient bit per
// cycle, unless the percentage is settled without division (signal lost, pulse
// out of bounds or zero span). The finished result sits in an output register,
// so the next item is taken while it waits. Configuration registers are
// written through cfg_we, cfg_index and cfg_data; the user must write them
// only while the block is idle (not enforced); writes beyond index 4 are ignored.
module rc_pwm_pulse_decoder #(
    parameter int TIMESTAMP_BITS = 48,
    parameter int DURATION_BITS  = 15
) (
    input  logic                      clk,
    input  logic                      rst_n,
    rpd_item_if.sink                  item,
    rpd_result_if.source              result,
    input  logic                      cfg_we,
    input  rpd_pkg::cfg_idx_t         cfg_index,
    input  logic [rpd_pkg::CFG_W-1:0] cfg_data
);
    import rpd_pkg::*;

    ctl_cmd_t    cmd;
    ctl_status_t status;

    rpd_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    rpd_datapath #(
        .TIMESTAMP_BITS (TIMESTAMP_BITS),
        .DURATION_BITS  (DURATION_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// File: src/rpd_ctrl.sv
// Controller state machine of the RC PWM pulse decoder.
// Depends on rpd_pkg; drives the datapath through ctl_cmd_t.
module rpd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rpd_pkg::ctl_status_t status,
    output rpd_pkg::ctl_cmd_t    cmd
);
    import rpd_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (status.in_valid)
                begin
                    state_next = status.in_action ? ST_AGE : ST_SYMBOL;
                end
            end
            ST_SYMBOL:
            begin
                state_next = status.is_last ? ST_COMMIT : ST_IDLE;
            end
            ST_COMMIT:
            begin
                state_next = ST_IDLE;
            end
            ST_AGE:
            begin
                state_next = ST_PREP;
            end
            ST_PREP:
            begin
                state_next = status.div_skip ? ST_RESULT : ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (status.div_last)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output logic.
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:   cmd.take = 1'b1;
            ST_SYMBOL:
            begin
                cmd.eval_symbol = 1'b1;
                cmd.measure     = 1'b1;
            end
            ST_COMMIT: cmd.commit = 1'b1;
            ST_AGE:    cmd.measure = 1'b1;
            ST_PREP:   cmd.prep = 1'b1;
            ST_DIVIDE: cmd.div_step = 1'b1;
            ST_RESULT: cmd.publish = status.out_free;
            default:   cmd = '0;
        endcase
    end

endmodule

// File: src/rpd_datapath.sv
// Datapath of the RC PWM pulse decoder: configuration registers, item
// capture, batch and timing state, percentage divider and result register.
// Depends on rpd_pkg and the channel interfaces in rpd_if.sv.
module rpd_datapath #(
    parameter int TIMESTAMP_BITS = 48,
    parameter int DURATION_BITS  = 15
) (
    input  logic                      clk,
    input  logic                      rst_n,
    rpd_item_if.sink                  item,
    rpd_result_if.source              result,
    input  logic                      cfg_we,
    input  rpd_pkg::cfg_idx_t         cfg_index,
    input  logic [rpd_pkg::CFG_W-1:0] cfg_data,
    input  rpd_pkg::ctl_cmd_t         cmd,
    output rpd_pkg::ctl_status_t      status
);
    import rpd_pkg::*;

    localparam int TS_W = TIMESTAMP_BITS;
    localparam int HW   = 16;

    // Configuration registers.
    logic [PULSE_W-1:0]   min_pulse_reg;
    logic [PULSE_W-1:0]   max_pulse_reg;
    logic [PERIOD_W-1:0]  min_period_reg;
    logic [PERIOD_W-1:0]  max_period_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;

    // Captured item.
    logic                     lv0_reg;
    logic                     lv1_reg;
    logic [DURATION_BITS-1:0] d0_reg;
    logic [DURATION_BITS-1:0] d1_reg;
    logic                     last_reg;
    logic [TS_W-1:0]          now_reg;

    // Decoder state.
    logic [PULSE_W-1:0]  stored_pulse_reg;
    logic [PERIOD_W-1:0] stored_period_reg;
    logic [TS_W-1:0]     last_update_reg;
    logic                has_update_reg;
    logic [PULSE_W-1:0]  batch_pulse_reg;
    logic                batch_found_reg;

    // Elapsed time since the last update.
    logic [TS_W-1:0] diff_reg;
    logic            borrow_reg;
    logic [TS_W:0]   diff_full;
    logic            after_last;

    // Percentage divider.
    logic             sig_valid_reg;
    logic [NUM_W-1:0] rem_reg;
    logic [DIV_W-1:0] div_reg;
    logic [PCT_W-1:0] pct_reg;
    logic [CNT_W-1:0] cnt_reg;

    // Result register.
    logic                out_valid_reg;
    logic [PULSE_W-1:0]  out_pulse_reg;
    logic [PERIOD_W-1:0] out_period_reg;
    logic                out_sig_valid_reg;
    logic [PCT_W-1:0]    out_pct_reg;

    // Combinational helpers.
    logic [HW-1:0]      high_time;
    logic               high_ok;
    logic               period_ok;
    logic               age_ok;
    logic               valid_now;
    logic               skip;
    logic [PCT_W-1:0]   skip_pct;
    logic [PULSE_W-1:0] span;
    logic [PULSE_W-1:0] offset;
    logic [NUM_W-1:0]   scaled;
    logic               ge;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_pulse_reg  <= RST_MIN_PULSE;
            max_pulse_reg  <= RST_MAX_PULSE;
            min_period_reg <= RST_MIN_PERIOD;
            max_period_reg <= RST_MAX_PERIOD;
            timeout_reg    <= RST_TIMEOUT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MIN_PULSE:  min_pulse_reg  <= cfg_data[PULSE_W-1:0];
                REG_MAX_PULSE:  max_pulse_reg  <= cfg_data[PULSE_W-1:0];
                REG_MIN_PERIOD: min_period_reg <= cfg_data[PERIOD_W-1:0];
                REG_MAX_PERIOD: max_period_reg <= cfg_data[PERIOD_W-1:0];
                REG_TIMEOUT:    timeout_reg    <= cfg_data[TIMEOUT_W-1:0];
                default:        ;
            endcase
        end
    end

    // Item capture on an accepted beat.
    assign item.ready = cmd.take;

    always_ff @(posedge clk)
    begin
        if (cmd.take && item.valid)
        begin
            lv0_reg  <= item.level_first;
            lv1_reg  <= item.level_second;
            d0_reg   <= item.duration_first;
            d1_reg   <= item.duration_second;
            last_reg <= item.batch_last;
            now_reg  <= item.now_us;
        end
    end

    // Elapsed time: one wide subtract, the borrow marks a timestamp before the
    // last update.
    assign diff_full  = {1'b0, now_reg} - {1'b0, last_update_reg};
    assign after_last = !borrow_reg && (diff_reg != '0);

    always_ff @(posedge clk)
    begin
        if (cmd.measure)
        begin
            diff_reg   <= diff_full[TS_W-1:0];
            borrow_reg <= diff_full[TS_W];
        end
    end

    // High time of the symbol and its bounds check.
    always_comb
    begin
        high_time = '0;
        high_ok   = 1'b0;
        if (lv0_reg && !lv1_reg)
        begin
            high_time = HW'(d0_reg);
            high_ok   = 1'b1;
        end
        else if (!lv0_reg && lv1_reg)
        begin
            high_time = HW'(d1_reg);
            high_ok   = 1'b1;
        end
        if (high_time < HW'(min_pulse_reg) || high_time > HW'(max_pulse_reg))
        begin
            high_ok = 1'b0;
        end
    end

    // Period window check at the batch commit.
    assign period_ok = has_update_reg && after_last
                       && diff_reg >= TS_W'(min_period_reg)
                       && diff_reg <= TS_W'(max_period_reg);

    // Batch and stored timing state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_pulse_reg  <= '0;
            stored_period_reg <= '0;
            last_update_reg   <= '0;
            has_update_reg    <= 1'b0;
            batch_pulse_reg   <= '0;
            batch_found_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.eval_symbol && high_ok)
            begin
                batch_pulse_reg <= high_time[PULSE_W-1:0];
                batch_found_reg <= 1'b1;
            end
            if (cmd.commit)
            begin
                if (batch_found_reg)
                begin
                    if (period_ok)
                    begin
                        stored_period_reg <= diff_reg[PERIOD_W-1:0];
                    end
                    stored_pulse_reg <= batch_pulse_reg;
                    last_update_reg  <= now_reg;
                    has_update_reg   <= 1'b1;
                end
                batch_found_reg <= 1'b0;
            end
        end
    end

    // Query preparation: validity, trivial percentages and divider setup.
    assign age_ok    = !after_last || diff_reg <= TS_W'(timeout_reg);
    assign valid_now = has_update_reg && age_ok;
    assign span      = max_pulse_reg - min_pulse_reg;
    assign offset    = stored_pulse_reg - min_pulse_reg;
    assign scaled    = NUM_W'(offset) * NUM_W'(PCT_FULL);

    always_comb
    begin
        skip     = 1'b1;
        skip_pct = '0;
        if (!valid_now || stored_pulse_reg < min_pulse_reg)
        begin
            skip_pct = '0;
        end
        else if (stored_pulse_reg > max_pulse_reg)
        begin
            skip_pct = PCT_FULL;
        end
        else if (span == '0)
        begin
            skip_pct = '0;
        end
        else
        begin
            skip = 1'b0;
        end
    end

    // Restoring divider, one quotient bit per step, most significant first.
    assign ge = rem_reg >= NUM_W'(div_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            sig_valid_reg <= valid_now;
            rem_reg       <= scaled;
            div_reg       <= {span, {(PCT_W-1){1'b0}}};
            cnt_reg       <= CNT_W'(PCT_W - 1);
            pct_reg       <= skip ? skip_pct : '0;
        end
        else if (cmd.div_step)
        begin
            if (ge)
            begin
                rem_reg <= rem_reg - NUM_W'(div_reg);
            end
            pct_reg <= {pct_reg[PCT_W-2:0], ge};
            div_reg <= div_reg >> 1;
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    // Result register: a finished result waits here while the next item is
    // taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.publish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            out_pulse_reg     <= stored_pulse_reg;
            out_period_reg    <= stored_period_reg;
            out_sig_valid_reg <= sig_valid_reg;
            out_pct_reg       <= pct_reg;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.pulse_width  = out_pulse_reg;
    assign result.period_width = out_period_reg;
    assign result.signal_ok    = out_sig_valid_reg;
    assign result.percentage   = out_pct_reg;

    // Status to the controller.
    always_comb
    begin
        status.in_valid  = item.valid;
        status.in_action = item.action;
        status.is_last   = last_reg;
        status.div_skip  = skip;
        status.div_last  = (cnt_reg == '0);
        status.out_free  = !out_valid_reg || result.ready;
    end

endmodule

// File: src/rpd_checker.sv
// Port-level checker of the RC PWM pulse decoder, bound to the top level.
// Depends on rpd_pkg and rc_pwm_pulse_decoder_macros.svh.
`include "rc_pwm_pulse_decoder_macros.svh"

module rpd_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        item_valid,
    input logic                        item_ready,
    input logic                        res_valid,
    input logic                        res_ready,
    input logic [rpd_pkg::PULSE_W-1:0] res_pulse,
    input logic                        res_sig_valid,
    input logic [rpd_pkg::PCT_W-1:0]   res_pct
);
    import rpd_pkg::*;

    logic res_stall;

    // A result beat is offered but not taken.
    assign res_stall = res_valid && !res_ready;

    // A waiting result beat holds its percentage and pulse width.
    `RPD_ASSERT_NEXT(a_res_hold, clk, rst_n, res_stall, res_valid && $stable({res_pct, res_pulse}))

    // After an accepted item beat, the block is not ready in the next cycle.
    `RPD_ASSERT_NEXT(a_busy_after_take, clk, rst_n, item_valid && item_ready, !item_ready)

    // The percentage never exceeds full scale.
    `RPD_ASSERT_NOW(a_pct_range, clk, rst_n, res_valid, res_pct <= PCT_FULL)

    // A lost signal reports zero throttle.
    `RPD_ASSERT_NOW(a_lost_zero, clk, rst_n, res_valid && !res_sig_valid, res_pct == '0)

endmodule

bind rc_pwm_pulse_decoder rpd_checker u_rpd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (item.valid),
    .item_ready    (item.ready),
    .res_valid     (result.valid),
    .res_ready     (result.ready),
    .res_pulse     (result.pulse_width),
    .res_sig_valid (result.signal_ok),
    .res_pct       (result.percentage)
);

// File: tb/rc_pwm_pulse_decoder_check.sv
// Scoreboard for the RC PWM pulse decoder: a small package with the item action
// codes, and a module that predicts every query result and compares it.
// Depends on rpd_pkg and the channel interfaces in rpd_if.sv.
`timescale 1ns / 1ps

package rpd_tb_pkg;

    // Kind of beat on the item channel.
    typedef enum logic {
        ACT_SYMBOL = 1'b0,
        ACT_QUERY  = 1'b1
    } rpd_action_t;

endpackage

module rc_pwm_pulse_decoder_check #(
    parameter int TIMESTAMP_BITS = 48
) (
    input  logic                      clk,
    input  logic                      rst_n,
    rpd_item_if                       item,
    rpd_result_if                     result,
    input  logic                      cfg_we,
    input  rpd_pkg::cfg_idx_t         cfg_index,
    input  logic [rpd_pkg::CFG_W-1:0] cfg_data,
    output int unsigned               failures,
    output int unsigned               pending
);
    import rpd_pkg::*;
    import rpd_tb_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [PULSE_W-1:0]  pulse_width;
        logic [PERIOD_W-1:0] period_width;
        logic                signal_ok;
        logic [PCT_W-1:0]    percentage;
    } throttle_report_t;

    // Register copies.
    logic [PULSE_W-1:0]   lo_pulse;
    logic [PULSE_W-1:0]   hi_pulse;
    logic [PERIOD_W-1:0]  lo_period;
    logic [PERIOD_W-1:0]  hi_period;
    logic [TIMEOUT_W-1:0] stale_after;

    // Decoder state as predicted.
    logic [PULSE_W-1:0]        kept_pulse;
    logic [PERIOD_W-1:0]       frame_interval;
    logic [TIMESTAMP_BITS-1:0] update_stamp;
    logic                      have_update;
    logic [PULSE_W-1:0]        batch_high;
    logic                      batch_hit;

    throttle_report_t report_q[$];
    int unsigned      fail_count;

    function automatic void write_register(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
        case (idx)
            REG_MIN_PULSE:  lo_pulse    = value[PULSE_W-1:0];
            REG_MAX_PULSE:  hi_pulse    = value[PULSE_W-1:0];
            REG_MIN_PERIOD: lo_period   = value[PERIOD_W-1:0];
            REG_MAX_PERIOD: hi_period   = value[PERIOD_W-1:0];
            REG_TIMEOUT:    stale_after = value[TIMEOUT_W-1:0];
            default: ;
        endcase
    endfunction

    // A symbol with opposite levels has a high time; it counts when in bounds.
    // The batch end commits the latest counted symbol and measures the period.
    function automatic void take_symbol(
        input logic lf, input logic [PULSE_W-1:0] df,
        input logic ls, input logic [PULSE_W-1:0] ds,
        input logic closes, input logic [TIMESTAMP_BITS-1:0] now
    );
        logic [PULSE_W-1:0]        high;
        logic [TIMESTAMP_BITS-1:0] gap;
        high = lf ? df : ds;
        if (lf != ls && high >= lo_pulse && high <= hi_pulse)
        begin
            batch_high = high;
            batch_hit  = 1'b1;
        end
        if (closes)
        begin
            if (batch_hit)
            begin
                if (have_update && now > update_stamp)
                begin
                    gap = now - update_stamp;
                    if (gap >= lo_period && gap <= hi_period)
                        frame_interval = gap[PERIOD_W-1:0];
                end
                kept_pulse   = batch_high;
                update_stamp = now;
                have_update  = 1'b1;
            end
            batch_hit = 1'b0;
        end
    endfunction

    function automatic logic [PCT_W-1:0] throttle_pct(input logic live);
        logic [PULSE_W-1:0] span;
        logic [31:0]        scaled;
        if (!live || kept_pulse < lo_pulse)
            return '0;
        if (kept_pulse > hi_pulse)
            return PCT_FULL;
        span = hi_pulse - lo_pulse;
        if (span == '0)
            return '0;
        scaled = 32'(kept_pulse - lo_pulse) * 32'd100 / 32'(span);
        return scaled[PCT_W-1:0];
    endfunction

    function automatic throttle_report_t query_report(input logic [TIMESTAMP_BITS-1:0] now);
        logic [TIMESTAMP_BITS-1:0] age;
        logic                      live;
        throttle_report_t          rep;
        age  = (now > update_stamp) ? now - update_stamp : '0;
        live = have_update && age <= stale_after;
        rep.pulse_width  = kept_pulse;
        rep.period_width = frame_interval;
        rep.signal_ok    = live;
        rep.percentage   = throttle_pct(live);
        return rep;
    endfunction

    // Watch both channels and the register port at every rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        throttle_report_t got;
        throttle_report_t want;
        if (!rst_n)
        begin
            lo_pulse       = RST_MIN_PULSE;
            hi_pulse       = RST_MAX_PULSE;
            lo_period      = RST_MIN_PERIOD;
            hi_period      = RST_MAX_PERIOD;
            stale_after    = RST_TIMEOUT;
            kept_pulse     = '0;
            frame_interval = '0;
            update_stamp   = '0;
            have_update    = 1'b0;
            batch_high     = '0;
            batch_hit      = 1'b0;
            report_q.delete();
            fail_count     = 0;
            failures <= 0;
            pending  <= 0;
        end
        else
        begin
            if (cfg_we)
                write_register(cfg_index, cfg_data);

            // Result beat: compare with the oldest prediction.
            if (result.valid && result.ready)
            begin
                got.pulse_width  = result.pulse_width;
                got.period_width = result.period_width;
                got.signal_ok    = result.signal_ok;
                got.percentage   = result.percentage;
                if (report_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("%0t: result beat with none predicted: pulse %0d period %0d",
                                 $time, got.pulse_width, got.period_width);
                end
                else
                begin
                    want = report_q.pop_front();
                    if (got.pulse_width !== want.pulse_width
                        || got.period_width !== want.period_width
                        || got.signal_ok !== want.signal_ok
                        || got.percentage !== want.percentage)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display("%0t: expected pulse %0d period %0d ok %0b pct %0d,",
                                     $time, want.pulse_width, want.period_width,
                                     want.signal_ok, want.percentage,
                                     " got pulse %0d period %0d ok %0b pct %0d",
                                     got.pulse_width, got.period_width,
                                     got.signal_ok, got.percentage);
                    end
                end
            end

            // Item beat: update the prediction.
            if (item.valid && item.ready)
            begin
                if (item.action == ACT_QUERY)
                    report_q.push_back(query_report(item.now_us));
                else
                    take_symbol(item.level_first, item.duration_first, item.level_second,
                                item.duration_second, item.batch_last, item.now_us);
            end

            pending  <= report_q.size();
            failures <= fail_count;
        end
    end

endmodule

// File: tb/rc_pwm_pulse_decoder_test.sv
// Top of the RC PWM pulse decoder testbench: clock, reset, register setup,
// directed and random stimulus, receiver stalls and the final verdict.
// Depends on rpd_pkg, rpd_if.sv, rc_pwm_pulse_decoder and its scoreboard.
`timescale 1ns / 1ps

module rc_pwm_pulse_decoder_test;
    import rpd_pkg::*;
    import rpd_tb_pkg::*;

    localparam int TS_W          = 48;
    localparam int DUR_W         = 15;
    localparam int RANDOM_ITEMS  = 1300;
    localparam int PHASES        = 6;
    localparam int SETTLE_CYCLES = 16;
    localparam int LIMIT_NS      = 10_000_000;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    cfg_idx_t          cfg_index;
    logic [CFG_W-1:0]  cfg_data;
    int unsigned       failures;
    int unsigned       pending;
    logic              calm;
    int unsigned       sent;
    logic [TS_W-1:0]   frame_time;
    logic [CFG_W-1:0]  cfg_shadow [5];

    rpd_item_if #(.TIMESTAMP_BITS(TS_W), .DURATION_BITS(DUR_W)) item ();
    rpd_result_if result ();

    rc_pwm_pulse_decoder #(
        .TIMESTAMP_BITS(TS_W),
        .DURATION_BITS (DUR_W)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    rc_pwm_pulse_decoder_check #(
        .TIMESTAMP_BITS(TS_W)
    ) decoder_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .failures (failures),
        .pending  (pending)
    );

    // 50 MHz clock.
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Receiver stalls with a chance of 8 percent, never while calm.
    always @(negedge clk)
        result.ready = calm || ($urandom_range(99) >= 8);

    // Run limit.
    initial
    begin
        #(LIMIT_NS);
        $display("CHECK FAILED");
        $finish;
    end

    // Send one beat, at times after a random gap, and wait for it to be taken.
    task automatic send_item(
        input rpd_action_t act,
        input logic lf, input logic [DUR_W-1:0] df,
        input logic ls, input logic [DUR_W-1:0] ds,
        input logic closes, input logic [TS_W-1:0] now
    );
        if (!calm && $urandom_range(99) < 8)
        begin
            item.valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        item.action          = act;
        item.level_first     = lf;
        item.duration_first  = df;
        item.level_second    = ls;
        item.duration_second = ds;
        item.batch_last      = closes;
        item.now_us          = now;
        item.valid           = 1'b1;
        @(posedge clk);
        while (!item.ready)
            @(posedge clk);
        sent++;
        @(negedge clk);
        item.valid = 1'b0;
    endtask

    task automatic send_symbol(
        input logic lf, input logic [DUR_W-1:0] df,
        input logic ls, input logic [DUR_W-1:0] ds,
        input logic closes, input logic [TS_W-1:0] now
    );
        send_item(ACT_SYMBOL, lf, df, ls, ds, closes, now);
    endtask

    task automatic send_query(input logic [TS_W-1:0] now);
        send_item(ACT_QUERY, 1'($urandom_range(1)), DUR_W'($urandom_range(32767)),
                  1'($urandom_range(1)), DUR_W'($urandom_range(32767)),
                  1'($urandom_range(1)), now);
    endtask

    // Wait until every predicted result has arrived, then let the block go idle.
    task automatic settle();
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx <= REG_TIMEOUT)
            cfg_shadow[idx] = value;
    endtask

    function automatic logic [TS_W-1:0] rand_stamp();
        logic [63:0] wide;
        wide = {$urandom(), $urandom()};
        return wide[TS_W-1:0];
    endfunction

    // High time around the pulse bounds, exact bounds included.
    function automatic logic [DUR_W-1:0] pick_high();
        int unsigned lo;
        int unsigned hi;
        lo = 32'(cfg_shadow[REG_MIN_PULSE]);
        hi = 32'(cfg_shadow[REG_MAX_PULSE]);
        if (lo > hi)
        begin
            lo = hi;
            hi = 32'(cfg_shadow[REG_MIN_PULSE]);
        end
        case ($urandom_range(9))
            0:       return DUR_W'(lo);
            1:       return DUR_W'(hi);
            2:       return DUR_W'((lo == 0) ? 0 : lo - 1);
            3:       return DUR_W'((hi == 32767) ? hi : hi + 1);
            4:       return DUR_W'($urandom_range(32767));
            default: return DUR_W'($urandom_range(hi, lo));
        endcase
    endfunction

    // Step between batch ends: mostly a legal frame period, sometimes none,
    // too short, too long or backward in time.
    function automatic logic [TS_W-1:0] pick_period();
        int unsigned lo;
        int unsigned hi;
        lo = 32'(cfg_shadow[REG_MIN_PERIOD]);
        hi = 32'(cfg_shadow[REG_MAX_PERIOD]);
        if (lo > hi)
        begin
            lo = hi;
            hi = 32'(cfg_shadow[REG_MIN_PERIOD]);
        end
        case ($urandom_range(11))
            0:       return TS_W'(lo);
            1:       return TS_W'(hi);
            2:       return TS_W'((lo == 0) ? 0 : lo - 1);
            3:       return TS_W'(hi + 1);
            4:       return '0;
            5:       return TS_W'($urandom_range(1000000, 70000));
            6:       return TS_W'(0) - TS_W'($urandom_range(50000, 1));
            default: return TS_W'($urandom_range(hi, lo));
        endcase
    endfunction

    // Query time relative to the last batch end, with the timeout edges and times before it.
    function automatic logic [TS_W-1:0] pick_age();
        int unsigned t;
        t = 32'(cfg_shadow[REG_TIMEOUT]);
        case ($urandom_range(9))
            0:       return '0;
            1:       return TS_W'(t);
            2:       return TS_W'(t) + TS_W'(1);
            3:       return TS_W'(0) - TS_W'($urandom_range(1000, 1));
            4:       return TS_W'($urandom());
            default: return TS_W'($urandom_range((t < 50000) ? t : 50000));
        endcase
    endfunction

    // One well-formed batch of 1 to 4 symbols, often followed by a query.
    task automatic send_frame();
        int unsigned     symbols;
        logic            lf;
        logic            ls;
        logic [DUR_W-1:0] hi_t;
        logic [DUR_W-1:0] lo_t;
        logic            closes;
        symbols    = $urandom_range(1, 4);
        frame_time = frame_time + pick_period();
        for (int s = 0; s < symbols; s++)
        begin
            hi_t   = pick_high();
            lo_t   = DUR_W'($urandom_range(32767));
            lf     = 1'($urandom_range(1));
            ls     = ($urandom_range(9) == 0) ? lf : !lf;
            closes = (s == symbols - 1);
            send_symbol(lf, lf ? hi_t : lo_t, ls, lf ? lo_t : hi_t, closes,
                        closes ? frame_time : rand_stamp());
        end
        if ($urandom_range(1))
            send_query(frame_time + pick_age());
    endtask

    task automatic send_noise();
        logic            closes;
        logic [TS_W-1:0] stamp;
        closes = 1'($urandom_range(1));
        stamp  = rand_stamp();
        send_item(rpd_action_t'($urandom_range(1)), 1'($urandom_range(1)),
                  DUR_W'($urandom_range(32767)), 1'($urandom_range(1)),
                  DUR_W'($urandom_range(32767)), closes, stamp);
        // Follow the jump now and then so that later frames measure from it.
        if (closes && $urandom_range(1))
            frame_time = stamp;
    endtask

    task automatic run_random(input int unsigned quota);
        int unsigned first;
        bit          paused;
        first  = sent;
        paused = 1'b0;
        while (sent - first < quota)
        begin
            // Halfway, hold back until every result has come out.
            if (!paused && sent - first >= quota / 2)
            begin
                settle();
                paused = 1'b1;
            end
            case ($urandom_range(19))
                0, 1, 2: send_query(frame_time + pick_age());
                3, 4, 5: send_noise();
                default: send_frame();
            endcase
        end
    endtask

    // Special cases under the reset register values.
    task automatic run_directed();
        logic [TS_W-1:0] top_stamp;
        top_stamp = '1;
        send_query(48'd0);
        // Equal levels are dropped and commit nothing.
        send_symbol(1'b1, 15'd1500, 1'b1, 15'd1500, 1'b1, 48'd1000);
        send_symbol(1'b0, 15'd1500, 1'b0, 15'd1500, 1'b1, 48'd1000);
        send_query(48'd1000);
        // Last in-bounds symbol of the batch wins; first update has no period.
        send_symbol(1'b1, 15'd1500, 1'b0, 15'd200, 1'b0, 48'd0);
        send_symbol(1'b0, 15'd300, 1'b1, 15'd1000, 1'b0, 48'd0);
        send_symbol(1'b1, 15'd999, 1'b0, 15'd0, 1'b1, 48'd50000);
        send_query(48'd50000);
        // Pulse at the upper bound, period at the lower bound.
        send_symbol(1'b0, 15'd0, 1'b1, 15'd2000, 1'b1, 48'd60000);
        send_query(48'd160000);
        send_query(48'd160001);
        // Period at the upper bound, then a pulse above the bound.
        send_symbol(1'b1, 15'd1500, 1'b0, 15'h7fff, 1'b1, 48'd90000);
        send_symbol(1'b1, 15'd2001, 1'b0, 15'd100, 1'b1, 48'd95000);
        // Periods just outside both bounds.
        send_symbol(1'b1, 15'd1999, 1'b0, 15'd100, 1'b1, 48'd120001);
        send_query(48'd120001);
        send_symbol(1'b0, 15'd10, 1'b1, 15'd1250, 1'b1, 48'd130000);
        // Query and update that are not after the last update.
        send_query(48'd100);
        send_symbol(1'b1, 15'd1750, 1'b0, 15'd1, 1'b1, 48'd130000);
        // Field extremes at the top of the time range.
        send_symbol(1'b1, 15'h7fff, 1'b0, 15'd0, 1'b1, top_stamp);
        send_query(top_stamp);
        send_symbol(1'b0, 15'h7fff, 1'b1, 15'd1500, 1'b1, top_stamp);
        send_query(top_stamp);
        send_query(48'd0);
        frame_time = top_stamp;
    endtask

    // Register settings per phase: reset values, widest, zero span and
    // zero timeout, inverted bounds, then random ones.
    task automatic configure(input int phase);
        int unsigned a;
        int unsigned b;
        case (phase)
            0:
            begin
                write_reg(REG_MIN_PULSE, CFG_W'(RST_MIN_PULSE));
                write_reg(REG_MAX_PULSE, CFG_W'(RST_MAX_PULSE));
                write_reg(REG_MIN_PERIOD, CFG_W'(RST_MIN_PERIOD));
                write_reg(REG_MAX_PERIOD, CFG_W'(RST_MAX_PERIOD));
                write_reg(REG_TIMEOUT, CFG_W'(RST_TIMEOUT));
            end
            1:
            begin
                write_reg(REG_MIN_PULSE, CFG_W'(0));
                write_reg(REG_MAX_PULSE, CFG_W'(32767));
                write_reg(REG_MIN_PERIOD, CFG_W'(0));
                write_reg(REG_MAX_PERIOD, CFG_W'(65535));
                write_reg(REG_TIMEOUT, '1);
            end
            2:
            begin
                write_reg(REG_MIN_PULSE, CFG_W'(1500));
                write_reg(REG_MAX_PULSE, CFG_W'(1500));
                write_reg(REG_MIN_PERIOD, CFG_W'(20000));
                write_reg(REG_MAX_PERIOD, CFG_W'(20000));
                write_reg(REG_TIMEOUT, CFG_W'(0));
            end
            3:
            begin
                write_reg(REG_MIN_PULSE, CFG_W'(2000));
                write_reg(REG_MAX_PULSE, CFG_W'(1000));
                write_reg(REG_MIN_PERIOD, CFG_W'(30000));
                write_reg(REG_MAX_PERIOD, CFG_W'(10000));
                write_reg(REG_TIMEOUT, CFG_W'(5000));
            end
            default:
            begin
                a = $urandom_range(1500, 500);
                b = a + $urandom_range(1500, 1);
                write_reg(REG_MIN_PULSE, CFG_W'(a));
                write_reg(REG_MAX_PULSE, CFG_W'(b));
                a = $urandom_range(20000);
                b = a + $urandom_range(40000);
                write_reg(REG_MIN_PERIOD, CFG_W'(a));
                write_reg(REG_MAX_PERIOD, CFG_W'((b > 65535) ? 65535 : b));
                write_reg(REG_TIMEOUT, CFG_W'($urandom_range(200000, 1000)));
            end
        endcase
        // Indexes past the register list must leave everything alone.
        write_reg(cfg_idx_t'($urandom_range(7, 5)), CFG_W'($urandom()));
    endtask

    // Main sequence.
    initial
    begin
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = REG_MIN_PULSE;
        cfg_data             = '0;
        item.valid           = 1'b0;
        item.action          = ACT_SYMBOL;
        item.level_first     = 1'b0;
        item.duration_first  = '0;
        item.level_second    = 1'b0;
        item.duration_second = '0;
        item.batch_last      = 1'b0;
        item.now_us          = '0;
        result.ready         = 1'b0;
        calm                 = 1'b0;
        sent                 = 0;
        frame_time           = '0;
        cfg_shadow[REG_MIN_PULSE]  = CFG_W'(RST_MIN_PULSE);
        cfg_shadow[REG_MAX_PULSE]  = CFG_W'(RST_MAX_PULSE);
        cfg_shadow[REG_MIN_PERIOD] = CFG_W'(RST_MIN_PERIOD);
        cfg_shadow[REG_MAX_PERIOD] = CFG_W'(RST_MAX_PERIOD);
        cfg_shadow[REG_TIMEOUT]    = CFG_W'(RST_TIMEOUT);
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        run_directed();
        for (int phase = 0; phase < PHASES; phase++)
        begin
            settle();
            configure(phase);
            // The widest setting runs with no idling on either side.
            calm = (phase == 1);
            run_random(RANDOM_ITEMS / PHASES);
        end
        settle();

        if (failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
